/* rtl/wsg_pkg.sv */
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, constants and waveform tables for the waveform sample
// generator.
// ----------------------------------------------------------------------------
package wsg_pkg;

  localparam int unsigned TimerClock = 4000000;
  localparam int unsigned DivSteps   = 22;
  localparam int unsigned CntW       = $clog2(DivSteps);
  localparam int unsigned DivisorW   = 21;
  localparam int unsigned ReloadW    = 21;
  localparam int unsigned MaxReload  = 2000000;

  typedef enum logic [1:0] {
    CFG_WAVEFORM  = 2'd0,
    CFG_FREQUENCY = 2'd1,
    CFG_AMPLITUDE = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_e;

  typedef enum logic [1:0] {
    WAVE_SQUARE   = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SINE     = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  function automatic logic [7:0] sine32(input logic [4:0] idx);
    logic [7:0] v;
    unique case (idx)
      5'd0:  v = 8'd128; 5'd1:  v = 8'd153; 5'd2:  v = 8'd178; 5'd3:  v = 8'd201;
      5'd4:  v = 8'd220; 5'd5:  v = 8'd236; 5'd6:  v = 8'd248; 5'd7:  v = 8'd254;
      5'd8:  v = 8'd255; 5'd9:  v = 8'd251; 5'd10: v = 8'd242; 5'd11: v = 8'd229;
      5'd12: v = 8'd211; 5'd13: v = 8'd190; 5'd14: v = 8'd166; 5'd15: v = 8'd140;
      5'd16: v = 8'd115; 5'd17: v = 8'd89;  5'd18: v = 8'd65;  5'd19: v = 8'd44;
      5'd20: v = 8'd26;  5'd21: v = 8'd13;  5'd22: v = 8'd4;   5'd23: v = 8'd0;
      5'd24: v = 8'd1;   5'd25: v = 8'd7;   5'd26: v = 8'd19;  5'd27: v = 8'd35;
      5'd28: v = 8'd54;  5'd29: v = 8'd77;  5'd30: v = 8'd102; 5'd31: v = 8'd128;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] sine60(input logic [5:0] idx);
    logic [7:0] v;
    case (idx)
      6'd0:  v = 8'd128; 6'd1:  v = 8'd141; 6'd2:  v = 8'd154; 6'd3:  v = 8'd167;
      6'd4:  v = 8'd180; 6'd5:  v = 8'd192; 6'd6:  v = 8'd203; 6'd7:  v = 8'd213;
      6'd8:  v = 8'd223; 6'd9:  v = 8'd231; 6'd10: v = 8'd238; 6'd11: v = 8'd244;
      6'd12: v = 8'd249; 6'd13: v = 8'd253; 6'd14: v = 8'd254; 6'd15: v = 8'd255;
      6'd16: v = 8'd254; 6'd17: v = 8'd253; 6'd18: v = 8'd249; 6'd19: v = 8'd244;
      6'd20: v = 8'd238; 6'd21: v = 8'd231; 6'd22: v = 8'd223; 6'd23: v = 8'd213;
      6'd24: v = 8'd203; 6'd25: v = 8'd192; 6'd26: v = 8'd180; 6'd27: v = 8'd167;
      6'd28: v = 8'd154; 6'd29: v = 8'd141; 6'd30: v = 8'd128; 6'd31: v = 8'd114;
      6'd32: v = 8'd101; 6'd33: v = 8'd88;  6'd34: v = 8'd75;  6'd35: v = 8'd64;
      6'd36: v = 8'd52;  6'd37: v = 8'd42;  6'd38: v = 8'd32;  6'd39: v = 8'd24;
      6'd40: v = 8'd17;  6'd41: v = 8'd11;  6'd42: v = 8'd6;   6'd43: v = 8'd2;
      6'd44: v = 8'd0;   6'd45: v = 8'd0;   6'd46: v = 8'd0;   6'd47: v = 8'd2;
      6'd48: v = 8'd6;   6'd49: v = 8'd11;  6'd50: v = 8'd17;  6'd51: v = 8'd24;
      6'd52: v = 8'd32;  6'd53: v = 8'd42;  6'd54: v = 8'd52;  6'd55: v = 8'd64;
      6'd56: v = 8'd75;  6'd57: v = 8'd88;  6'd58: v = 8'd101; 6'd59: v = 8'd114;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/wsg_ctrl.sv */
// ----------------------------------------------------------------------------
// wsg_ctrl
// Sequencer for one tick: phase update, amplitude scaling, reload division
// and hand-off to the output register.
// ----------------------------------------------------------------------------
module wsg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_valid_i,
  input  logic             tick_i,
  output logic             tick_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  wsg_pkg::status_t status_i,
  output wsg_pkg::cmd_t    cmd_o
);

  wsg_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;

  assign tick_stall_o = (state_q != wsg_pkg::ST_IDLE);
  assign accept       = tick_valid_i && !tick_stall_o;
  assign out_valid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      wsg_pkg::ST_IDLE: begin
        if (accept && tick_i) begin
          cmd_o.load = 1'b1;
          state_d    = wsg_pkg::ST_SCALE;
        end
      end
      wsg_pkg::ST_SCALE: begin
        cmd_o.setup = 1'b1;
        state_d     = wsg_pkg::ST_DIVIDE;
      end
      wsg_pkg::ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = wsg_pkg::ST_DONE;
        end
      end
      wsg_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = wsg_pkg::ST_IDLE;
        end
      end
      default: state_d = wsg_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/wsg_datapath.sv */
// ----------------------------------------------------------------------------
// wsg_datapath
// Configuration registers, per-waveform phase state, amplitude scaling and
// a restoring divider for the timer reload count.
// ----------------------------------------------------------------------------
module wsg_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [12:0]                  cfg_data_i,
  input  wsg_pkg::cmd_t                cmd_i,
  output wsg_pkg::status_t             status_o,
  output logic [7:0]                   sample_o,
  output logic [wsg_pkg::ReloadW-1:0]  reload_count_o
);

  localparam int unsigned DivW = wsg_pkg::DivSteps;

  logic [1:0]  waveform_q;
  logic [12:0] freq_q;
  logic [7:0]  amp_q;

  logic        square_high_q, square_high_d;
  logic [7:0]  tri_level_q, tri_level_d;
  logic        tri_falling_q, tri_falling_d;
  logic [5:0]  sine_index_q, sine_index_d;
  logic [7:0]  saw_level_q, saw_level_d;

  logic [7:0]                     level_q, level_d;
  logic [wsg_pkg::DivisorW-1:0]   div_q, div_d;
  logic [15:0]                    prod_q;
  logic [wsg_pkg::DivisorW-1:0]   rem_q;
  logic [DivW-1:0]                quo_q;
  logic [wsg_pkg::CntW-1:0]       cnt_q;
  logic [7:0]                     sample_q;
  logic [wsg_pkg::ReloadW-1:0]    reload_q;

  logic [12:0] f_eff;
  logic [13:0] base;
  logic [7:0]  mul_k;
  logic [8:0]  tri_up;
  logic [7:0]  tri_step;
  logic [5:0]  sine_idx;
  logic [7:0]  saw_next;
  logic [DivW-1:0] trial;
  logic        trial_ge;
  logic [15:0] scale_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= 2'd0;
      freq_q     <= 13'd10;
      amp_q      <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (wsg_pkg::cfg_index_e'(cfg_index_i))
        wsg_pkg::CFG_WAVEFORM:  waveform_q <= cfg_data_i[1:0];
        wsg_pkg::CFG_FREQUENCY: freq_q     <= cfg_data_i;
        wsg_pkg::CFG_AMPLITUDE: amp_q      <= cfg_data_i[7:0];
        wsg_pkg::CFG_UNUSED:    ;
        default:                ;
      endcase
    end
  end

  assign f_eff = (freq_q == 13'd0) ? 13'd1 : freq_q;

  always_comb begin
    square_high_d = square_high_q;
    tri_level_d   = tri_level_q;
    tri_falling_d = tri_falling_q;
    sine_index_d  = sine_index_q;
    saw_level_d   = saw_level_q;
    level_d       = 8'd0;
    base          = 14'(f_eff) + 14'd100;
    mul_k         = 8'd32;
    tri_step      = (f_eff < 13'd1000) ? 8'd4 : 8'd16;
    tri_up        = {1'b0, tri_level_q} + {1'b0, tri_step};
    sine_idx      = 6'd0;
    saw_next      = saw_level_q + ((f_eff < 13'd2000) ? 8'd4 : 8'd8);
    unique case (wsg_pkg::wave_e'(waveform_q))
      wsg_pkg::WAVE_SQUARE: begin
        level_d       = square_high_q ? 8'd0 : 8'd255;
        square_high_d = !square_high_q;
        base          = {1'b0, f_eff};
        mul_k         = 8'd2;
      end
      wsg_pkg::WAVE_TRIANGLE: begin
        level_d = tri_level_q;
        if (!tri_falling_q) begin
          if (tri_up >= ((f_eff < 13'd1000) ? 9'd253 : 9'd241)) begin
            tri_level_d   = 8'd255;
            tri_falling_d = 1'b1;
          end else begin
            tri_level_d   = tri_up[7:0];
            tri_falling_d = (tri_up >= 9'd247);
          end
        end else begin
          if (tri_level_q < ((f_eff < 13'd1000) ? 8'd9 : 8'd31)) begin
            tri_level_d   = 8'd0;
            tri_falling_d = 1'b0;
          end else begin
            tri_level_d = tri_level_q - tri_step;
          end
        end
        if (f_eff < 13'd1000) begin
          base  = {1'b0, f_eff};
          mul_k = 8'd128;
        end
      end
      wsg_pkg::WAVE_SINE: begin
        if (f_eff < 13'd2500) begin
          sine_idx     = (sine_index_q > 6'd59) ? 6'd0 : sine_index_q;
          level_d      = wsg_pkg::sine60(sine_idx);
          sine_index_d = (sine_idx == 6'd59) ? 6'd0 : sine_idx + 6'd1;
          base         = {1'b0, f_eff};
          mul_k        = 8'd60;
        end else begin
          sine_idx     = (sine_index_q > 6'd31) ? 6'd0 : sine_index_q;
          level_d      = wsg_pkg::sine32(sine_idx[4:0]);
          sine_index_d = (sine_idx == 6'd31) ? 6'd0 : sine_idx + 6'd1;
        end
      end
      wsg_pkg::WAVE_SAWTOOTH: begin
        level_d     = saw_level_q;
        saw_level_d = (saw_next == 8'd255) ? 8'd0 : saw_next;
        if (f_eff < 13'd2000) begin
          base  = {1'b0, f_eff};
          mul_k = 8'd64;
        end
      end
      default: ;
    endcase
    div_d = {13'd0, mul_k} * {7'd0, base};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      square_high_q <= 1'b0;
      tri_level_q   <= 8'd0;
      tri_falling_q <= 1'b0;
      sine_index_q  <= 6'd0;
      saw_level_q   <= 8'd0;
    end else if (cmd_i.load) begin
      square_high_q <= square_high_d;
      tri_level_q   <= tri_level_d;
      tri_falling_q <= tri_falling_d;
      sine_index_q  <= sine_index_d;
      saw_level_q   <= saw_level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      cnt_q <= wsg_pkg::CntW'(wsg_pkg::DivSteps - 1);
    end else if (cmd_i.step && cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign status_o.div_last = (cnt_q == '0);

  assign trial    = {rem_q, quo_q[DivW-1]};
  assign trial_ge = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      level_q <= level_d;
      div_q   <= div_d;
    end
    if (cmd_i.setup) begin
      prod_q <= {8'd0, level_q} * {8'd0, amp_q};
      rem_q  <= '0;
      quo_q  <= DivW'(wsg_pkg::TimerClock);
    end else if (cmd_i.step) begin
      rem_q <= trial_ge ? wsg_pkg::DivisorW'(trial - {1'b0, div_q})
                        : trial[wsg_pkg::DivisorW-1:0];
      quo_q <= {quo_q[DivW-2:0], trial_ge};
    end
  end

  // Exact divide by 255 for any product of two 8-bit values.
  assign scale_sum = prod_q + {8'd0, prod_q[15:8]} + 16'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_q <= scale_sum[15:8];
      reload_q <= quo_q[wsg_pkg::ReloadW-1:0];
    end
  end

  assign sample_o       = sample_q;
  assign reload_count_o = reload_q;

endmodule

/* rtl/waveform_sample_generator.sv */
// ----------------------------------------------------------------------------
// waveform_sample_generator
// Function generator core: one DAC sample and the next timer reload count
// for each timer tick, in square, triangle, sine or sawtooth mode.
// ----------------------------------------------------------------------------
// Usage: the timer offers a tick beat on tick_valid_i/tick_i; the block takes
// it when tick_stall_o is low. A beat with tick_i low is taken and produces
// nothing. A beat with tick_i high produces one result beat on out_valid_o
// with sample_o and reload_count_o, taken when out_stall_i is low.
// The work runs in order: the phase update and divisor product, then the
// amplitude product, then the bit-serial restoring divider that forms
// 4000000 / divisor, then the load of the output register. No new tick is
// taken before that load. The output register holds a result while the
// receiver stalls; the next tick is worked on meanwhile and waits in its
// final step until the register frees up. Reset sets waveform to square,
// frequency to 10 Hz, amplitude to 255 and clears all phase state. The user
// must make configuration writes only while no tick is in flight; the block
// itself does not enforce this.
module waveform_sample_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        tick_valid_i,
  output logic        tick_stall_o,
  input  logic        tick_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  sample_o,
  output logic [20:0] reload_count_o
);

  wsg_pkg::cmd_t    cmd;
  wsg_pkg::status_t status;

  wsg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (tick_valid_i),
    .tick_i       (tick_i),
    .tick_stall_o (tick_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  wsg_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_o       (sample_o),
    .reload_count_o (reload_count_o)
  );

`ifndef NO_ASSERTIONS
  a_tick_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_i && !tick_stall_o && tick_i) |=> tick_stall_o)
    else $error("Accepted tick did not start work.");

  a_empty_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_i && !tick_stall_o && !tick_i) |=> !tick_stall_o)
    else $error("Empty tick started work.");

  a_reload_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reload_count_o <= 21'(wsg_pkg::MaxReload)))
    else $error("Reload count out of range.");

  a_no_result_when_busy_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_i && !tick_stall_o && tick_i) |=> ##1 tick_stall_o)
    else $error("Tick finished too early.");
`endif

endmodule
